[rtl/core/ale_pkg.sv]
// ale_pkg: shared sizes, request, status and state codes for the array list engine
// used by array_list_engine_unit; no dependencies

package ale_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned AddrWidth  = $clog2(CAPACITY);
  localparam int unsigned CntWidth   = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    REQ_INSERT    = 3'd0,
    REQ_APPEND    = 3'd1,
    REQ_READ      = 3'd2,
    REQ_OVERWRITE = 3'd3,
    REQ_SEARCH    = 3'd4,
    REQ_CLEAR     = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_PUT   = 7'b0001000,
    S_SRCH  = 7'b0010000,
    S_RDW   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

endpackage

[rtl/core/array_list_engine_unit.sv]
// array_list_engine_unit: bounded ordered list of signed words in a single-port-write ram
// depends on ale_pkg

// Append, overwrite, clear and refused requests go from exec straight to fin; a read
// passes through rdw; an insert at position p into a list of length n moves the n - p
// entries from p up in shift, the ram moving one entry per cycle, then writes the item
// in put; a search makes one ram read per entry. The input is ready only while the
// engine is idle; a finished result waits in the output register while the engine
// returns to idle. capacity_limit may only be written while idle.
module array_list_engine_unit
  import ale_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CntWidth-1:0]          cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   req_type_i,
  input  logic [AddrWidth-1:0]         position_i,
  input  logic signed [DATA_WIDTH-1:0] item_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic signed [DATA_WIDTH-1:0] read_value_o,
  output logic [AddrWidth-1:0]         found_index_o,
  output logic [CntWidth-1:0]          list_length_o,
  output logic                         is_empty_o,
  output logic                         is_full_o
);

  logic [DATA_WIDTH-1:0] entry_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_q;
  logic                  mem_we;
  logic [AddrWidth-1:0]  mem_wa, mem_ra;
  logic [DATA_WIDTH-1:0] mem_wd;

  state_e                state_q, state_d;
  logic [CntWidth-1:0]   cap_q, cap_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic [2:0]            req_q, req_d;
  logic [AddrWidth-1:0]  pos_q, pos_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [AddrWidth-1:0]  idx_q, idx_d;
  logic                  pend_q, pend_d;
  logic [AddrWidth-1:0]  pend_addr_q, pend_addr_d;
  logic [CntWidth-1:0]   scan_q, scan_d;
  logic [1:0]            res_status_q, res_status_d;
  logic [DATA_WIDTH-1:0] res_rd_q, res_rd_d;
  logic [AddrWidth-1:0]  res_found_q, res_found_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_status_q, out_status_d;
  logic [DATA_WIDTH-1:0] out_rd_q, out_rd_d;
  logic [AddrWidth-1:0]  out_found_q, out_found_d;
  logic [CntWidth-1:0]   out_len_q, out_len_d;
  logic                  out_empty_q, out_empty_d;
  logic                  out_full_q, out_full_d;

  logic [CntWidth-1:0]   lim;
  logic [CntWidth-1:0]   pos_ext;
  logic                  is_full_now;
  logic                  out_free;

  assign lim         = (cap_q < CntWidth'(CAPACITY)) ? cap_q : CntWidth'(CAPACITY);
  assign pos_ext     = {1'b0, pos_q};
  assign is_full_now = (count_q >= lim);
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
    rd_q <= entry_mem[mem_ra];
  end

  always_comb begin
    state_d      = state_q;
    cap_d        = cfg_we_i ? cfg_wdata_i : cap_q;
    count_d      = count_q;
    req_d        = req_q;
    pos_d        = pos_q;
    word_d       = word_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    scan_d       = scan_q;
    res_status_d = res_status_q;
    res_rd_d     = res_rd_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_rd_d     = out_rd_q;
    out_found_d  = out_found_q;
    out_len_d    = out_len_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;
    mem_we       = 1'b0;
    mem_wa       = pos_q;
    mem_wd       = word_q;
    mem_ra       = pos_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_type_i;
          pos_d   = position_i;
          word_d  = item_value_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = ST_OK;
        res_rd_d     = '0;
        res_found_d  = '0;
        state_d      = S_FIN;
        case (req_q)
          REQ_INSERT: begin
            if (pos_ext > count_q || pos_ext >= lim) begin
              res_status_d = ST_RANGE;
            end else if (is_full_now) begin
              res_status_d = ST_FULL;
            end else begin
              idx_d   = count_q[AddrWidth-1:0];
              pend_d  = 1'b0;
              state_d = S_SHIFT;
            end
          end
          REQ_APPEND: begin
            if (is_full_now) begin
              res_status_d = ST_FULL;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = count_q[AddrWidth-1:0];
              count_d = count_q + CntWidth'(1);
            end
          end
          REQ_READ: begin
            if (pos_ext >= count_q) begin
              res_status_d = ST_RANGE;
            end else begin
              state_d = S_RDW;
            end
          end
          REQ_OVERWRITE: begin
            if (pos_ext >= count_q) begin
              res_status_d = ST_RANGE;
            end else begin
              mem_we = 1'b1;
            end
          end
          REQ_SEARCH: begin
            res_status_d = ST_NOT_FOUND;
            scan_d       = '0;
            pend_d       = 1'b0;
            state_d      = S_SRCH;
          end
          REQ_CLEAR: begin
            count_d = '0;
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        // read entry idx-1 while the entry read last cycle lands one slot up
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = pend_addr_q;
          mem_wd = rd_q;
        end
        if (idx_q > pos_q) begin
          mem_ra      = idx_q - AddrWidth'(1);
          pend_d      = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = idx_q - AddrWidth'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        mem_we  = 1'b1;
        count_d = count_q + CntWidth'(1);
        state_d = S_FIN;
      end
      S_SRCH: begin
        // pend_q marks that rd_q holds entry pend_addr_q for comparison
        if (pend_q && rd_q == word_q) begin
          res_status_d = ST_OK;
          res_found_d  = pend_addr_q;
          pend_d       = 1'b0;
          state_d      = S_FIN;
        end else if (scan_q < count_q) begin
          mem_ra      = scan_q[AddrWidth-1:0];
          pend_d      = 1'b1;
          pend_addr_d = scan_q[AddrWidth-1:0];
          scan_d      = scan_q + CntWidth'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = S_FIN;
        end
      end
      S_RDW: begin
        res_rd_d = rd_q;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_rd_d     = res_rd_q;
          out_found_d  = res_found_q;
          out_len_d    = count_q;
          out_empty_d  = (count_q == '0);
          out_full_d   = is_full_now;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CntWidth'(CAPACITY);
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    pos_q        <= pos_d;
    word_q       <= word_d;
    idx_q        <= idx_d;
    pend_addr_q  <= pend_addr_d;
    scan_q       <= scan_d;
    res_status_q <= res_status_d;
    res_rd_q     <= res_rd_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_rd_q     <= out_rd_d;
    out_found_q  <= out_found_d;
    out_len_q    <= out_len_d;
    out_empty_q  <= out_empty_d;
    out_full_q   <= out_full_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_rd_q;
  assign found_index_o = out_found_q;
  assign list_length_o = out_len_q;
  assign is_empty_o    = out_empty_q;
  assign is_full_o     = out_full_q;

endmodule
